// ===== src/m3di_pkg.sv =====
// Shared widths, types and helpers for the 3x3 determinant / inverse unit.
// No dependencies; imported by every module of the block.
package m3di_pkg;

    localparam int N_ELEM     = 9;                    // elements per matrix
    localparam int A_W        = 24;                   // Q8.16 input element
    localparam int PROD_W     = 48;                   // element by element product
    localparam int ADJ_W      = 48;                   // cofactor, signed
    localparam int HALF_W     = 24;                   // cofactor split for det products
    localparam int DET_W      = 74;                   // exact determinant, signed, 2^48 scale
    localparam int DMAG_W     = DET_W - 1;            // determinant magnitude
    localparam int NUM_W      = ADJ_W + 32;           // dividend |adj| << 32
    localparam int QB         = 33;                   // quotient bits kept (32 down to 0)
    localparam int DIV_STAGES = QB + 1;               // overflow check plus one stage per bit
    localparam int CMP_W      = DMAG_W + QB;          // width of the shifted divisor
    localparam int OUT_W      = 32;                   // Q16.16 result element
    localparam int SAT_W      = DMAG_W - 32;          // magnitude fed to the saturator
    localparam int PRE_STAGES = 5;                    // cofactor and determinant stages
    localparam int DEPTH      = PRE_STAGES + DIV_STAGES;
    localparam int IN_DATA_W  = N_ELEM * A_W;
    localparam int OUT_DATA_W = (N_ELEM + 1) * OUT_W;

    typedef logic signed [A_W-1:0]    elem_t;
    typedef logic signed [OUT_W-1:0]  res_t;
    typedef logic [ADJ_W-1:0]         adj_mag_t;
    typedef logic [DMAG_W-1:0]        dmag_t;

    // Status that runs beside the division lanes
    typedef struct packed {
        logic        zero;        // exact determinant is zero
        res_t        det_value;   // determinant, Q16.16 saturated
    } fwd_t;

    // Cofactor product operands: cofactor k = P[2k] - P[2k+1]
    localparam int unsigned PA [18] = '{4, 7, 2, 1, 1, 2, 5, 3, 0, 2, 3, 0, 3, 6, 6, 0, 0, 3};
    localparam int unsigned PB [18] = '{8, 5, 7, 8, 5, 4, 6, 8, 8, 6, 2, 5, 7, 4, 1, 7, 4, 1};

    // Apply sign to a magnitude and clamp to 32-bit two's complement
    function automatic res_t sat32(input logic [SAT_W-1:0] mag, input logic neg);
        res_t r;
        if (neg) begin
            if (mag > SAT_W'(33'h0_8000_0000))
                r = 32'sh8000_0000;
            else
                r = res_t'(-mag[OUT_W-1:0]);
        end
        else begin
            if (mag > SAT_W'(33'h0_7FFF_FFFF))
                r = 32'sh7FFF_FFFF;
            else
                r = res_t'(mag[OUT_W-1:0]);
        end
        return r;
    endfunction

endpackage

// ===== src/m3di_adj.sv =====
// Cofactor and exact determinant pipeline (five register stages).
// Depends on m3di_pkg.
module m3di_adj (
    input  logic                   clk,
    input  logic                   en,
    input  m3di_pkg::elem_t        a       [m3di_pkg::N_ELEM],
    output m3di_pkg::adj_mag_t     adj_mag [m3di_pkg::N_ELEM],
    output logic                   adj_neg [m3di_pkg::N_ELEM],
    output m3di_pkg::dmag_t        dmag,
    output logic                   dneg,
    output m3di_pkg::fwd_t         fwd
);
    import m3di_pkg::*;

    logic signed [PROD_W-1:0]   prod_reg [18];
    elem_t                      r0_p1_reg [3];
    elem_t                      r0_p2_reg [3];
    logic signed [ADJ_W-1:0]    adj_p2_reg [N_ELEM];
    logic signed [ADJ_W-1:0]    adj_p3_reg [N_ELEM];
    logic signed [ADJ_W-1:0]    adj_p4_reg [N_ELEM];
    logic signed [47:0]         phi_reg [3];
    logic signed [48:0]         plo_reg [3];
    logic signed [DET_W-1:0]    det_reg;
    logic signed [DET_W-1:0]    det_next;
    dmag_t                      dmag_reg;
    logic                       dneg_reg;
    logic                       dzero_reg;
    adj_mag_t                   amag_reg [N_ELEM];
    logic                       aneg_reg [N_ELEM];

    // Stage 1: the eighteen cofactor products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 18; k++)
                prod_reg[k] <= a[PA[k]] * a[PB[k]];
            for (int k = 0; k < 3; k++)
                r0_p1_reg[k] <= a[k];
        end
    end

    // Stage 2: cofactors
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N_ELEM; k++)
                adj_p2_reg[k] <= prod_reg[2*k] - prod_reg[2*k+1];
            r0_p2_reg <= r0_p1_reg;
        end
    end

    // Stage 3: first-row terms as two 24x24 partial products each
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int t = 0; t < 3; t++)
            begin
                phi_reg[t] <= r0_p2_reg[t] * $signed(adj_p2_reg[3*t][ADJ_W-1:HALF_W]);
                plo_reg[t] <= r0_p2_reg[t] * $signed({1'b0, adj_p2_reg[3*t][HALF_W-1:0]});
            end
            adj_p3_reg <= adj_p2_reg;
        end
    end

    // Stage 4: recombine and sum into the exact determinant
    always_comb
    begin
        det_next = '0;
        for (int t = 0; t < 3; t++)
            det_next = det_next + (DET_W'(phi_reg[t]) <<< HALF_W) + DET_W'(plo_reg[t]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg    <= det_next;
            adj_p4_reg <= adj_p3_reg;
        end
    end

    // Stage 5: sign and magnitude of determinant and cofactors
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dneg_reg  <= det_reg[DET_W-1];
            dmag_reg  <= det_reg[DET_W-1] ? DMAG_W'(-det_reg) : DMAG_W'(det_reg);
            dzero_reg <= (det_reg == '0);
            for (int k = 0; k < N_ELEM; k++)
            begin
                aneg_reg[k] <= adj_p4_reg[k][ADJ_W-1];
                amag_reg[k] <= adj_p4_reg[k][ADJ_W-1] ? adj_mag_t'(-adj_p4_reg[k])
                                                      : adj_mag_t'(adj_p4_reg[k]);
            end
        end
    end

    assign adj_mag       = amag_reg;
    assign adj_neg       = aneg_reg;
    assign dmag          = dmag_reg;
    assign dneg          = dneg_reg;
    assign fwd.zero      = dzero_reg;
    assign fwd.det_value = sat32(dmag_reg[DMAG_W-1:32], dneg_reg);

endmodule

// ===== src/m3di_div_lane.sv =====
// One division lane: (|cofactor| << 32) / |det|, one quotient bit per stage,
// then sign and saturation. Depends on m3di_pkg.
module m3di_div_lane (
    input  logic                 clk,
    input  logic                 en,
    input  m3di_pkg::adj_mag_t   mag_in,
    input  logic                 neg_in,
    input  m3di_pkg::dmag_t      dmag_in,
    output m3di_pkg::res_t       q_out
);
    import m3di_pkg::*;

    logic [NUM_W-1:0]  r_reg [DIV_STAGES];
    logic [QB-1:0]     q_reg [DIV_STAGES];
    logic              ovf_reg [DIV_STAGES];
    dmag_t             d_reg [DIV_STAGES];
    logic              n_reg [DIV_STAGES];
    logic [NUM_W-1:0]  num;

    assign num = {mag_in, 32'b0};

    // First stage: quotient of 2^33 or more always saturates
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= num;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (CMP_W'(num) >= {dmag_in, QB'(0)});
            d_reg[0]   <= dmag_in;
            n_reg[0]   <= neg_in;
        end
    end

    // Restoring steps, bit 32 down to bit 0
    for (genvar j = 1; j < DIV_STAGES; j++)
    begin : g_step
        localparam int SH = DIV_STAGES - 1 - j;
        logic [CMP_W-1:0] rx, dx, diff;
        logic             ge;

        always_comb
        begin
            rx   = CMP_W'(r_reg[j-1]);
            dx   = CMP_W'(d_reg[j-1]) << SH;
            ge   = (rx >= dx);
            diff = rx - dx;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j]   <= ge ? diff[NUM_W-1:0] : r_reg[j-1];
                q_reg[j]   <= q_reg[j-1] | (ge ? (QB'(1) << SH) : QB'(0));
                ovf_reg[j] <= ovf_reg[j-1];
                d_reg[j]   <= d_reg[j-1];
                n_reg[j]   <= n_reg[j-1];
            end
        end
    end

    assign q_out = sat32(ovf_reg[DIV_STAGES-1] ? '1 : SAT_W'(q_reg[DIV_STAGES-1]),
                         n_reg[DIV_STAGES-1]);

endmodule

// ===== src/matrix3_determinant_inverse_unit.sv =====
// Top level: 3x3 determinant and inverse, nine division lanes and a merge stage.
// Depends on m3di_pkg, m3di_adj and m3di_div_lane.
//
//  channel | dir | tdata                              | tuser
//  s_*     | in  | a_00..a_22, 24 b each, 216 b       | -
//  m_*     | out | inv_00..inv_22, det_value, 320 b   | invertible
//
// One matrix per cycle while s_tready is high; a request passes the 39 pipeline
// stages and then the output register, and the 34-stage divider is most of the depth.
// rst_n clears only the valid bits of the pipeline, output register and skid stage.
// A stalled result sits in the output register, a second one in the skid
// stage; s_tready drops only while the skid stage is full.
module matrix3_determinant_inverse_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [m3di_pkg::IN_DATA_W-1:0]      s_tdata,   // a_00, a_01, ... a_22
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [m3di_pkg::OUT_DATA_W-1:0]     m_tdata,   // inv_00 .. inv_22, det_value
    output logic                                m_tuser    // invertible
);
    import m3di_pkg::*;

    elem_t                     a [N_ELEM];
    adj_mag_t                  adj_mag [N_ELEM];
    logic                      adj_neg [N_ELEM];
    dmag_t                     dmag;
    logic                      dneg;
    fwd_t                      fwd;
    fwd_t                      fwd_dly_reg [DIV_STAGES];
    res_t                      inv [N_ELEM];
    logic [DEPTH-1:0]          vld_reg;
    logic                      en;
    logic [OUT_DATA_W-1:0]     res_data;
    logic                      res_user;
    logic                      out_valid_reg;
    logic [OUT_DATA_W-1:0]     out_data_reg;
    logic                      out_user_reg;
    logic                      skid_valid_reg;
    logic [OUT_DATA_W-1:0]     skid_data_reg;
    logic                      skid_user_reg;
    logic                      out_take;

    // Unpack request
    always_comb
    begin
        for (int k = 0; k < N_ELEM; k++)
            a[k] = elem_t'(s_tdata[k*A_W +: A_W]);
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    m3di_adj u_adj (
        .clk     (clk),
        .en      (en),
        .a       (a),
        .adj_mag (adj_mag),
        .adj_neg (adj_neg),
        .dmag    (dmag),
        .dneg    (dneg),
        .fwd     (fwd)
    );

    // Division lanes, one per inverse element
    for (genvar k = 0; k < N_ELEM; k++)
    begin : g_lane
        m3di_div_lane u_lane (
            .clk     (clk),
            .en      (en),
            .mag_in  (adj_mag[k]),
            .neg_in  (adj_neg[k] ^ dneg),
            .dmag_in (dmag),
            .q_out   (inv[k])
        );
    end

    // Determinant status delayed alongside the lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fwd_dly_reg[0] <= fwd;
            for (int s = 1; s < DIV_STAGES; s++)
                fwd_dly_reg[s] <= fwd_dly_reg[s-1];
        end
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
    end

    // Merge: singular matrices give all-zero results
    always_comb
    begin
        res_data = '0;
        if (!fwd_dly_reg[DIV_STAGES-1].zero)
        begin
            for (int k = 0; k < N_ELEM; k++)
                res_data[k*OUT_W +: OUT_W] = inv[k];
            res_data[N_ELEM*OUT_W +: OUT_W] = fwd_dly_reg[DIV_STAGES-1].det_value;
        end
        res_user = !fwd_dly_reg[DIV_STAGES-1].zero;
    end

    assign out_take = out_valid_reg && m_tready;

    // Output register and skid stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (vld_reg[DEPTH-1])
        begin
            if (out_valid_reg && !m_tready)
                skid_valid_reg <= 1'b1;
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register and skid stage payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end
        else if (vld_reg[DEPTH-1])
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_data_reg <= res_data;
                skid_user_reg <= res_user;
            end
            else
            begin
                out_data_reg <= res_data;
                out_user_reg <= res_user;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while output register is empty");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("singular result carries nonzero data");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready && vld_reg[DEPTH-1]))
        else $error("skid stage filled without a stalled output");

endmodule
